// ===== rtl/lsa_pkg.sv =====
// Shared types and constants of the level sensor slow averager.
// Used by every module of the block but lsa_ram; depends on nothing.
`default_nettype none
package lsa_pkg;

  localparam int SAMPLES    = 16;
  localparam int LEVEL_W    = 12;
  localparam int TIME_W     = 31;
  localparam int NEXT_W     = 32;
  localparam int INTV_W     = 8;
  localparam int IDX_W      = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int CNT_W      = $clog2(SAMPLES + 1);
  localparam int SUM_W      = LEVEL_W + CNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SAMPLES - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(SAMPLES);

  localparam logic [LEVEL_W-1:0] EMPTY_RESET = 12'd4095;
  localparam logic [INTV_W-1:0]  START_RESET = 8'd1;
  localparam logic [INTV_W-1:0]  LIMIT_RESET = 8'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMPTY_READING  = 2'd0,
    REG_INTERVAL_START = 2'd1,
    REG_INTERVAL_LIMIT = 2'd2,
    REG_RAW_MODE       = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCHED,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] raw_reading;
    logic [TIME_W-1:0]  now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               updated;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

// ===== rtl/lsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module lsa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lsa_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on lsa_pkg for widths and the request struct.
`default_nettype none
module lsa_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lsa_pkg::div_req_t       req,
  output logic                         done,
  output logic [lsa_pkg::SUM_W-1:0]    quotient
);

  localparam int REM_W = lsa_pkg::CNT_W + 1;
  localparam int DCNT_W = $clog2(lsa_pkg::SUM_W + 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [DCNT_W-1:0]          cnt_r, cnt_nxt;
  logic [lsa_pkg::SUM_W-1:0]  quo_r, quo_nxt;
  logic [REM_W-1:0]           rem_r, rem_nxt;
  logic [lsa_pkg::CNT_W-1:0]  dvsr_r, dvsr_nxt;
  logic [REM_W-1:0]           rem_sh;
  logic                       ge;

  assign rem_sh = {rem_r[REM_W-2:0], quo_r[lsa_pkg::SUM_W-1]};
  assign ge     = rem_sh >= REM_W'(dvsr_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(lsa_pkg::SUM_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[lsa_pkg::SUM_W-2:0], ge};
      rem_nxt = ge ? (rem_sh - REM_W'(dvsr_r)) : rem_sh;
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/level_sensor_slow_averager_unit.sv =====
// Top level of the level sensor slow averager: sequencer, sample ring, registers.
// Depends on lsa_pkg, lsa_ram and lsa_div.
//
// Each request takes one converted level, |raw_reading - empty_reading|, and
// returns one result. A raw-mode request goes from ST_IDLE straight to ST_DONE.
// Otherwise the level is written into a 16-entry sample ring in ST_WRITE; a
// request that does not trigger an update then goes to ST_DONE, and one that does
// (first request after reset, or now_seconds past the scheduled time) passes
// ST_SCHED, reads back the filled ring entries one per cycle through the ring's
// single read port in ST_SUM and then divides the sum by the fill count in a
// serial divider at one quotient bit per cycle in ST_DIV. in_ready is low while a
// request is being worked on; a finished result waits in the output register
// while the next request is accepted, and a result still waiting there holds the
// last step of the following request. The configuration port is always ready;
// the user must see that it is written only while the block is idle, as the
// block itself does not enforce this.
`default_nettype none
module level_sensor_slow_averager_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire lsa_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output lsa_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lsa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  lsa_pkg::state_t state_r, state_nxt;

  logic [lsa_pkg::LEVEL_W-1:0] empty_r, empty_nxt;
  logic [lsa_pkg::INTV_W-1:0]  start_r, start_nxt;
  logic [lsa_pkg::INTV_W-1:0]  limit_r, limit_nxt;
  logic                        raw_r, raw_nxt;

  logic [lsa_pkg::CNT_W-1:0]   fill_r, fill_nxt;
  logic [lsa_pkg::IDX_W-1:0]   widx_r, widx_nxt;
  logic [lsa_pkg::LEVEL_W-1:0] held_r, held_nxt;
  logic                        started_r, started_nxt;
  logic [lsa_pkg::NEXT_W-1:0]  next_time_r, next_time_nxt;
  logic [lsa_pkg::INTV_W-1:0]  intv_r, intv_nxt;

  logic [lsa_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [lsa_pkg::TIME_W-1:0]  now_r, now_nxt;
  logic                        upd_r, upd_nxt;
  logic [lsa_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic                        pend_r, pend_nxt;
  logic [lsa_pkg::SUM_W-1:0]   sum_r, sum_nxt;

  logic                        out_valid_r, out_valid_nxt;
  lsa_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                        ram_we;
  logic [lsa_pkg::LEVEL_W-1:0] ram_rdata;
  lsa_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [lsa_pkg::SUM_W-1:0]   div_quo;
  logic [lsa_pkg::LEVEL_W-1:0] in_level;

  assign in_level = (in_data.raw_reading >= empty_r) ? (in_data.raw_reading - empty_r)
                                                     : (empty_r - in_data.raw_reading);

  lsa_ram #(
    .WIDTH (lsa_pkg::LEVEL_W),
    .DEPTH (lsa_pkg::SAMPLES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_r),
    .wdata (level_r),
    .raddr (idx_r[lsa_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  lsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    empty_nxt     = empty_r;
    start_nxt     = start_r;
    limit_nxt     = limit_r;
    raw_nxt       = raw_r;
    fill_nxt      = fill_r;
    widx_nxt      = widx_r;
    held_nxt      = held_r;
    started_nxt   = started_r;
    next_time_nxt = next_time_r;
    intv_nxt      = intv_r;
    level_nxt     = level_r;
    now_nxt       = now_r;
    upd_nxt       = upd_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    div_req       = '{start: 1'b0, dividend: sum_r, divisor: fill_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      case (lsa_pkg::cfg_reg_t'(cfg_index))
        lsa_pkg::REG_EMPTY_READING: begin
          empty_nxt = cfg_data[lsa_pkg::LEVEL_W-1:0];
        end
        lsa_pkg::REG_INTERVAL_START: begin
          start_nxt = cfg_data[lsa_pkg::INTV_W-1:0];
          if (!started_r) begin
            intv_nxt = cfg_data[lsa_pkg::INTV_W-1:0];
          end
        end
        lsa_pkg::REG_INTERVAL_LIMIT: begin
          limit_nxt = cfg_data[lsa_pkg::INTV_W-1:0];
        end
        lsa_pkg::REG_RAW_MODE: begin
          raw_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      lsa_pkg::ST_IDLE: begin
        if (in_valid) begin
          level_nxt = in_level;
          now_nxt   = in_data.now_seconds;
          upd_nxt   = 1'b0;
          if (raw_r) begin
            held_nxt  = in_level;
            state_nxt = lsa_pkg::ST_DONE;
          end else begin
            state_nxt = lsa_pkg::ST_WRITE;
          end
        end
      end
      lsa_pkg::ST_WRITE: begin
        ram_we   = 1'b1;
        widx_nxt = (widx_r == lsa_pkg::LAST_IDX) ? '0 : widx_r + lsa_pkg::IDX_W'(1);
        if (fill_r != lsa_pkg::FULL_CNT) begin
          fill_nxt = fill_r + lsa_pkg::CNT_W'(1);
        end
        if (!started_r || (next_time_r < lsa_pkg::NEXT_W'(now_r))) begin
          started_nxt = 1'b1;
          if (intv_r < limit_r) begin
            intv_nxt = intv_r + lsa_pkg::INTV_W'(1);
          end
          state_nxt = lsa_pkg::ST_SCHED;
        end else begin
          state_nxt = lsa_pkg::ST_DONE;
        end
      end
      lsa_pkg::ST_SCHED: begin
        next_time_nxt = lsa_pkg::NEXT_W'(now_r) + lsa_pkg::NEXT_W'(intv_r);
        idx_nxt       = '0;
        sum_nxt       = '0;
        state_nxt     = lsa_pkg::ST_SUM;
      end
      lsa_pkg::ST_SUM: begin
        if (pend_r) begin
          sum_nxt = sum_r + lsa_pkg::SUM_W'(ram_rdata);
        end
        if (idx_r != fill_r) begin
          idx_nxt  = idx_r + lsa_pkg::CNT_W'(1);
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          div_req.start = 1'b1;
          state_nxt     = lsa_pkg::ST_DIV;
        end
      end
      lsa_pkg::ST_DIV: begin
        if (div_done) begin
          held_nxt  = div_quo[lsa_pkg::LEVEL_W-1:0];
          upd_nxt   = 1'b1;
          state_nxt = lsa_pkg::ST_DONE;
        end
      end
      lsa_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.level   = held_r;
          out_data_nxt.updated = upd_r;
          state_nxt            = lsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsa_pkg::ST_IDLE;
      empty_r     <= lsa_pkg::EMPTY_RESET;
      start_r     <= lsa_pkg::START_RESET;
      limit_r     <= lsa_pkg::LIMIT_RESET;
      raw_r       <= 1'b0;
      fill_r      <= '0;
      widx_r      <= '0;
      held_r      <= '0;
      started_r   <= 1'b0;
      next_time_r <= '0;
      intv_r      <= lsa_pkg::START_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      empty_r     <= empty_nxt;
      start_r     <= start_nxt;
      limit_r     <= limit_nxt;
      raw_r       <= raw_nxt;
      fill_r      <= fill_nxt;
      widx_r      <= widx_nxt;
      held_r      <= held_nxt;
      started_r   <= started_nxt;
      next_time_r <= next_time_nxt;
      intv_r      <= intv_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    level_r    <= level_nxt;
    now_r      <= now_nxt;
    upd_r      <= upd_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == lsa_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/lsa_checker.sv =====
// Port-level checker for the level sensor slow averager, bound to the top level.
// Depends on lsa_pkg and level_sensor_slow_averager_unit.
`default_nettype none
module lsa_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire lsa_pkg::in_item_t              in_data,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire lsa_pkg::out_item_t             out_data,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [lsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [lsa_pkg::CFG_DATA_W-1:0] cfg_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed or dropped while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in work");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
    else $error("configuration write stalled or unknown");

endmodule

bind level_sensor_slow_averager_unit lsa_checker u_lsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
`default_nettype wire
